### sv/level_and_overtemp_alarm_leds_unit_macros.svh
// Assertion macros shared by the checker of the level and overtemp alarm LED unit.
`ifndef LEVEL_AND_OVERTEMP_ALARM_LEDS_UNIT_MACROS_SVH
`define LEVEL_AND_OVERTEMP_ALARM_LEDS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LVL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LVL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/lvlalarm_pkg.sv
// Types, constants and helpers of the level and overtemp alarm LED unit.
package lvlalarm_pkg;

  localparam int TIMER_BITS = 8;
  localparam int CFG_BITS   = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam int REM_BITS   = CMP_BITS + 1;
  localparam int STEP_BITS  = (TIMER_BITS > 1) ? $clog2(TIMER_BITS) : 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_ABOVE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_AT_MOST     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MEDIUM_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_PERIOD      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACK_TIMEOUT     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_PERIOD    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_PHASE_END = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_CYCLE_END = 3'd7;

  localparam logic [CFG_BITS-1:0] RST_HIGH_ABOVE      = 8'd18;
  localparam logic [CFG_BITS-1:0] RST_LOW_AT_MOST     = 8'd4;
  localparam logic [CFG_BITS-1:0] RST_MEDIUM_PERIOD   = 8'd20;
  localparam logic [CFG_BITS-1:0] RST_LOW_PERIOD      = 8'd10;
  localparam logic [CFG_BITS-1:0] RST_ACK_TIMEOUT     = 8'd150;
  localparam logic [CFG_BITS-1:0] RST_FLASH_PERIOD    = 8'd2;
  localparam logic [CFG_BITS-1:0] RST_FLASH_PHASE_END = 8'd50;
  localparam logic [CFG_BITS-1:0] RST_FLASH_CYCLE_END = 8'd100;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_AWAIT  = 2'd1;
  localparam logic [1:0] MODE_FLASH  = 2'd2;

  localparam logic [1:0] REGION_LOW    = 2'd0;
  localparam logic [1:0] REGION_MEDIUM = 2'd1;
  localparam logic [1:0] REGION_HIGH   = 2'd2;

  typedef struct packed {
    logic [7:0] battery_level;
    logic [7:0] fuel_level;
    logic       over_temp;
    logic       acknowledge;
  } in_word_t;

  typedef struct packed {
    logic       led_all_ok;
    logic       led_battery;
    logic       led_fuel;
    logic       battery_low;
    logic       fuel_low;
    logic       temp_warning;
    logic [1:0] alarm_mode;
  } out_word_t;

  function automatic logic [1:0] region_of(input logic [7:0] level,
                                           input logic [CFG_BITS-1:0] high_above,
                                           input logic [CFG_BITS-1:0] low_at_most);
    logic [1:0] r;
    if (level > high_above) r = REGION_HIGH;
    else if (level <= low_at_most) r = REGION_LOW;
    else r = REGION_MEDIUM;
    return r;
  endfunction

  function automatic logic [CFG_BITS-1:0] nonzero(input logic [CFG_BITS-1:0] p);
    return (p == '0) ? CFG_BITS'(1) : p;
  endfunction

endpackage

### sv/lvlalarm_if.sv
// Valid/ready channels that carry the tick word and the result word.
interface lvlalarm_in_if import lvlalarm_pkg::*;;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lvlalarm_out_if import lvlalarm_pkg::*;;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/level_and_overtemp_alarm_leds_unit.sv
// Top level of the level and overtemp alarm LED unit.
// Each accepted tick word goes through the states in order: S_IDLE takes the word,
// S_DIV_A and S_DIV_B are for the two timer remainders, which a single bit-serial
// remainder unit works out one after the other, and S_APPLY updates the state and
// loads the result register once any earlier result is taken. The result register
// holds a finished word until it is taken while the next tick is already accepted.
module level_and_overtemp_alarm_leds_unit import lvlalarm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  lvlalarm_in_if.sink             tick,
  lvlalarm_out_if.source          result,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV_A = 4'b0010,
    S_DIV_B = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  logic [CFG_BITS-1:0] high_above, low_at_most, medium_period, low_period;
  logic [CFG_BITS-1:0] ack_timeout, flash_period, flash_phase_end, flash_cycle_end;

  state_t               state;
  logic [1:0]           mode;
  logic [TIMER_BITS-1:0] ack_wait_timer, battery_timer, fuel_timer, flash_timer;
  logic                 battery_phase, fuel_phase, warning_flag;
  logic [2:0]           led_levels;

  in_word_t             word;
  logic [TIMER_BITS-1:0] dvd;
  logic [CFG_BITS-1:0]  div_p;
  logic [REM_BITS-1:0]  rem;
  logic [STEP_BITS-1:0] step;
  logic                 zero_a, zero_b;
  logic                 out_valid;
  out_word_t            out_data;
  logic                 apply_fire;

  logic [REM_BITS-1:0]  rem_sh, rem_step;
  logic                 last_step;
  logic [1:0]           rb, rf, rb_in, mode_in;

  assign tick.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign apply_fire   = (state == S_APPLY) && (!out_valid || result.ready);

  assign rb_in   = region_of(tick.data.battery_level, high_above, low_at_most);
  assign mode_in = (tick.data.over_temp && mode == MODE_NORMAL) ? MODE_AWAIT : mode;
  assign rb      = region_of(word.battery_level, high_above, low_at_most);
  assign rf      = region_of(word.fuel_level, high_above, low_at_most);

  // Shared restoring remainder step, one dividend bit a cycle.
  always_comb begin
    rem_sh   = {rem[REM_BITS-2:0], dvd[TIMER_BITS-1]};
    rem_step = (rem_sh >= REM_BITS'(div_p)) ? rem_sh - REM_BITS'(div_p) : rem_sh;
  end
  assign last_step = (step == STEP_BITS'(TIMER_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      high_above      <= RST_HIGH_ABOVE;
      low_at_most     <= RST_LOW_AT_MOST;
      medium_period   <= RST_MEDIUM_PERIOD;
      low_period      <= RST_LOW_PERIOD;
      ack_timeout     <= RST_ACK_TIMEOUT;
      flash_period    <= RST_FLASH_PERIOD;
      flash_phase_end <= RST_FLASH_PHASE_END;
      flash_cycle_end <= RST_FLASH_CYCLE_END;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_ABOVE:      high_above      <= cfg_data;
        CFG_LOW_AT_MOST:     low_at_most     <= cfg_data;
        CFG_MEDIUM_PERIOD:   medium_period   <= cfg_data;
        CFG_LOW_PERIOD:      low_period      <= cfg_data;
        CFG_ACK_TIMEOUT:     ack_timeout     <= cfg_data;
        CFG_FLASH_PERIOD:    flash_period    <= cfg_data;
        CFG_FLASH_PHASE_END: flash_phase_end <= cfg_data;
        CFG_FLASH_CYCLE_END: flash_cycle_end <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next values of the tick state, used in the apply cycle.
  logic [1:0]            mode_next;
  logic [TIMER_BITS-1:0] awt_next, bt_next, ft_next, fl_next;
  logic                  bp_next, fp_next, warn_next;
  logic [2:0]            led_next;
  logic                  high_a, high_b;

  always_comb begin
    mode_next = (word.over_temp && mode == MODE_NORMAL) ? MODE_AWAIT : mode;
    awt_next  = ack_wait_timer;
    bt_next   = battery_timer;
    ft_next   = fuel_timer;
    fl_next   = flash_timer;
    bp_next   = battery_phase;
    fp_next   = fuel_phase;
    warn_next = warning_flag;
    led_next  = led_levels;
    high_a    = (rb == REGION_HIGH);
    high_b    = (rf == REGION_HIGH);
    if (mode_next != MODE_FLASH) begin
      if (mode_next == MODE_AWAIT) begin
        warn_next = 1'b1;
        if (CMP_BITS'(ack_wait_timer) == CMP_BITS'(ack_timeout)) begin
          mode_next = MODE_FLASH;
          awt_next  = '0;
        end else begin
          awt_next = ack_wait_timer + TIMER_BITS'(1);
        end
        if (word.acknowledge) begin
          warn_next = 1'b0;
          mode_next = MODE_NORMAL;
          awt_next  = '0;
        end
      end
      if (high_a && high_b) begin
        led_next = 3'b100;
      end else begin
        led_next[2] = 1'b0;
        if (high_a) begin
          bp_next     = 1'b0;
          led_next[1] = 1'b0;
          bt_next     = battery_timer + TIMER_BITS'(1);
        end else if (zero_a) begin
          bp_next     = ~battery_phase;
          led_next[1] = ~battery_phase;
          bt_next     = TIMER_BITS'(1);
        end else begin
          bt_next = battery_timer + TIMER_BITS'(1);
        end
        if (high_b) begin
          fp_next     = 1'b0;
          led_next[0] = 1'b0;
          ft_next     = fuel_timer + TIMER_BITS'(1);
        end else if (zero_b) begin
          fp_next     = ~fuel_phase;
          led_next[0] = ~fuel_phase;
          ft_next     = TIMER_BITS'(1);
        end else begin
          ft_next = fuel_timer + TIMER_BITS'(1);
        end
      end
    end else begin
      if (word.acknowledge) begin
        warn_next = 1'b0;
        mode_next = MODE_NORMAL;
        awt_next  = '0;
      end
      led_next[2] = 1'b0;
      if (CMP_BITS'(flash_timer) < CMP_BITS'(flash_phase_end)) begin
        if (zero_a) begin
          bp_next     = ~battery_phase;
          led_next[1] = ~battery_phase;
          fp_next     = ~fuel_phase;
          led_next[0] = ~fuel_phase;
        end
        fl_next = flash_timer + TIMER_BITS'(1);
      end else if (CMP_BITS'(flash_timer) < CMP_BITS'(flash_cycle_end)) begin
        bp_next     = 1'b1;
        fp_next     = 1'b1;
        led_next[1] = 1'b1;
        led_next[0] = 1'b1;
        fl_next     = flash_timer + TIMER_BITS'(1);
      end else begin
        fl_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode           <= MODE_NORMAL;
      ack_wait_timer <= '0;
      battery_timer  <= '0;
      fuel_timer     <= '0;
      flash_timer    <= '0;
      battery_phase  <= 1'b0;
      fuel_phase     <= 1'b0;
      led_levels     <= '0;
      warning_flag   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (apply_fire) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            state <= S_DIV_A;
          end
        end
        S_DIV_A: begin
          if (last_step) state <= S_DIV_B;
        end
        S_DIV_B: begin
          if (last_step) state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_fire) begin
            mode           <= mode_next;
            ack_wait_timer <= awt_next;
            battery_timer  <= bt_next;
            fuel_timer     <= ft_next;
            flash_timer    <= fl_next;
            battery_phase  <= bp_next;
            fuel_phase     <= fp_next;
            led_levels     <= led_next;
            warning_flag   <= warn_next;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Remainder unit operands and the captured word.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        word <= tick.data;
        rem  <= '0;
        step <= '0;
        if (mode_in == MODE_FLASH) begin
          dvd   <= flash_timer;
          div_p <= nonzero(flash_period);
        end else begin
          dvd   <= battery_timer;
          div_p <= nonzero((rb_in == REGION_MEDIUM) ? medium_period : low_period);
        end
      end
      S_DIV_A: begin
        if (last_step) begin
          zero_a <= (rem_step == '0);
          rem    <= '0;
          step   <= '0;
          dvd    <= fuel_timer;
          div_p  <= nonzero((rf == REGION_MEDIUM) ? medium_period : low_period);
        end else begin
          rem  <= rem_step;
          step <= step + STEP_BITS'(1);
          dvd  <= {dvd[TIMER_BITS-2:0], 1'b0};
        end
      end
      S_DIV_B: begin
        if (last_step) begin
          zero_b <= (rem_step == '0);
        end else begin
          rem  <= rem_step;
          step <= step + STEP_BITS'(1);
          dvd  <= {dvd[TIMER_BITS-2:0], 1'b0};
        end
      end
      S_APPLY: begin
        if (apply_fire) begin
          out_data.led_all_ok   <= led_next[2];
          out_data.led_battery  <= led_next[1];
          out_data.led_fuel     <= led_next[0];
          out_data.battery_low  <= (rb == REGION_LOW);
          out_data.fuel_low     <= (rf == REGION_LOW);
          out_data.temp_warning <= warn_next;
          out_data.alarm_mode   <= mode_next;
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/lvlalarm_checker.sv
// Port-level checker of the level and overtemp alarm LED unit and its bind.
`include "level_and_overtemp_alarm_leds_unit_macros.svh"

module lvlalarm_checker import lvlalarm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      tick_valid,
  input logic      tick_ready,
  input logic      result_valid,
  input logic      result_ready,
  input out_word_t result_data
);

  `LVL_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_data))
  `LVL_ASSERT_NEXT(a_busy_after_accept, clk, rst, tick_valid && tick_ready, !tick_ready)
  `LVL_ASSERT_SAME(a_ok_excl, clk, rst, result_valid && result_data.led_all_ok, !result_data.led_battery && !result_data.led_fuel)
  `LVL_ASSERT_SAME(a_warn_mode, clk, rst, result_valid, result_data.temp_warning == (result_data.alarm_mode != MODE_NORMAL))

endmodule

bind level_and_overtemp_alarm_leds_unit lvlalarm_checker chk (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);
